FILE: src/iptc_pkg.sv
// Shared types, constants and helpers for the IPv4 port traffic counter.
`default_nettype none

package iptc_pkg;

  // Sizing
  localparam int PORT_BITS       = 16;
  localparam int COUNTER_BITS    = 64;
  localparam int MAX_FRAME_BYTES = 16383;

  localparam int OFFSET_W   = $clog2(MAX_FRAME_BYTES + 1);
  localparam int TBL_AW     = PORT_BITS + 2;
  localparam int TBL_DEPTH  = 1 << TBL_AW;
  localparam int TBL_W      = 2 * COUNTER_BITS;
  localparam int TOTAL_W    = 64;
  localparam int PORT_W     = 16;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // Stream payload widths
  localparam int S_DATA_W = 8;
  localparam int M_DATA_W = PORT_W + 2 * TOTAL_W;
  localparam int M_USER_W = 3;

  // Protocol constants
  localparam int          ETH_HDR_LEN = 14;
  localparam int          IP_MIN_LEN  = 20;
  localparam int          TCP_HDR_LEN = 20;
  localparam int          UDP_HDR_LEN = 8;
  localparam int          IHL_MIN     = 5;
  localparam logic [7:0]  PROTO_TCP   = 8'd6;
  localparam logic [7:0]  PROTO_UDP   = 8'd17;
  localparam logic [15:0] ETYPE_IPV4  = 16'h0800;

  // Header byte positions
  localparam int POS_ETYPE_HI = 12;
  localparam int POS_ETYPE_LO = 13;
  localparam int POS_IHL      = 14;
  localparam int POS_PROTO    = 23;
  localparam int POS_L4_MIN   = 24;

  // Frame summary handed from the parser to the update side
  typedef struct packed {
    logic                counted;
    logic                dir;
    logic                udp;
    logic [PORT_W-1:0]   port;
    logic [OFFSET_W-1:0] ip_bytes;  // frame length minus Ethernet header
  } frame_desc_t;

  // Table index: {direction, udp, low port bits}
  function automatic logic [TBL_AW-1:0] tbl_index(input frame_desc_t d);
    tbl_index = {d.dir, d.udp, d.port[PORT_BITS-1:0]};
  endfunction

endpackage

`default_nettype wire

FILE: src/iptc_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module iptc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: src/iptc_parser.sv
// Front end: parses frame bytes and builds one frame summary per frame.
`default_nettype none

module iptc_parser (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 accept_i,
  input  wire logic [7:0]           byte_i,
  input  wire logic                 last_i,
  input  wire logic                 dir_i,
  output logic                      push_o,
  output iptc_pkg::frame_desc_t     desc_o
);

  import iptc_pkg::*;

  logic [OFFSET_W-1:0] offset_q, offset_d;
  logic [15:0]         etype_q, etype_d;
  logic [3:0]          ihl_q, ihl_d;
  logic [7:0]          proto_q, proto_d;
  logic [15:0]         sport_q, sport_d;
  logic [15:0]         dport_q, dport_d;

  logic [OFFSET_W-1:0] l4_pos;
  logic [OFFSET_W-1:0] hdr_need;
  logic                cap_en;
  logic                udp;
  logic                ok;

  // Header capture for the current byte
  always_comb begin
    cap_en   = offset_q < OFFSET_W'(MAX_FRAME_BYTES);
    l4_pos   = OFFSET_W'(ETH_HDR_LEN) + OFFSET_W'({ihl_q, 2'b00});
    offset_d = offset_q;
    etype_d  = etype_q;
    ihl_d    = ihl_q;
    proto_d  = proto_q;
    sport_d  = sport_q;
    dport_d  = dport_q;
    if (cap_en) begin
      offset_d = offset_q + 1'b1;
      if (offset_q == OFFSET_W'(POS_ETYPE_HI)) etype_d[15:8] = byte_i;
      if (offset_q == OFFSET_W'(POS_ETYPE_LO)) etype_d[7:0]  = byte_i;
      if (offset_q == OFFSET_W'(POS_IHL))      ihl_d         = byte_i[3:0];
      if (offset_q == OFFSET_W'(POS_PROTO))    proto_d       = byte_i;
      if (offset_q >= OFFSET_W'(POS_L4_MIN)) begin
        if (offset_q == l4_pos)                sport_d[15:8] = byte_i;
        if (offset_q == l4_pos + 1'b1)         sport_d[7:0]  = byte_i;
        if (offset_q == l4_pos + 2'd2)         dport_d[15:8] = byte_i;
        if (offset_q == l4_pos + 2'd3)         dport_d[7:0]  = byte_i;
      end
    end
  end

  // Counting decision on the updated header fields
  always_comb begin
    udp      = proto_d == PROTO_UDP;
    hdr_need = OFFSET_W'(ETH_HDR_LEN) + OFFSET_W'({ihl_d, 2'b00})
             + (udp ? OFFSET_W'(UDP_HDR_LEN) : OFFSET_W'(TCP_HDR_LEN));
    ok = (offset_d >= OFFSET_W'(ETH_HDR_LEN + IP_MIN_LEN))
      && (etype_d == ETYPE_IPV4)
      && (ihl_d >= 4'(IHL_MIN))
      && ((proto_d == PROTO_TCP) || udp)
      && (offset_d >= hdr_need);

    desc_o = '0;
    if (ok) begin
      desc_o.counted  = 1'b1;
      desc_o.dir      = dir_i;
      desc_o.udp      = udp;
      desc_o.port     = dir_i ? sport_d : dport_d;
      desc_o.ip_bytes = offset_d - OFFSET_W'(ETH_HDR_LEN);
    end
    push_o = accept_i && last_i;
  end

  // Parse state, cleared after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      etype_q  <= '0;
      ihl_q    <= '0;
      proto_q  <= '0;
      sport_q  <= '0;
      dport_q  <= '0;
    end else if (accept_i) begin
      if (last_i) begin
        offset_q <= '0;
        etype_q  <= '0;
        ihl_q    <= '0;
        proto_q  <= '0;
        sport_q  <= '0;
        dport_q  <= '0;
      end else begin
        offset_q <= offset_d;
        etype_q  <= etype_d;
        ihl_q    <= ihl_d;
        proto_q  <= proto_d;
        sport_q  <= sport_d;
        dport_q  <= dport_d;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/iptc_fifo.sv
// Short queue of frame summaries between the parser and the update side.
`default_nettype none

module iptc_fifo (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire iptc_pkg::frame_desc_t desc_i,
  output logic                      full_o,
  input  wire logic                 pop_i,
  output logic                      valid_o,
  output iptc_pkg::frame_desc_t     desc_o
);

  import iptc_pkg::*;

  frame_desc_t        slot_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_q, rptr_q;
  logic [FIFO_CW-1:0] count_q;
  logic               do_push, do_pop;

  assign full_o  = count_q == FIFO_CW'(FIFO_DEPTH);
  assign valid_o = count_q != '0;
  assign desc_o  = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= desc_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + 1'b1;
      if (do_pop)  rptr_q <= rptr_q + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  // Checks
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("summary pushed into a full queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FIFO_CW'(FIFO_DEPTH))
    else $error("queue fill level out of range");

endmodule

`default_nettype wire

FILE: src/iptc_update.sv
// Back end: table clearing, read-modify-write of the counters, output register.
`default_nettype none

module iptc_update (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            q_valid_i,
  input  wire iptc_pkg::frame_desc_t           q_desc_i,
  output logic                                 q_pop_o,
  output logic                                 clr_busy_o,
  output logic                                 m_valid_o,
  input  wire logic                            m_ready_i,
  output logic [iptc_pkg::M_DATA_W-1:0]        m_data_o,
  output logic [iptc_pkg::M_USER_W-1:0]        m_user_o
);

  import iptc_pkg::*;

  logic                    clr_q;
  logic [TBL_AW-1:0]       clr_addr_q;

  logic                    b_valid_q;
  frame_desc_t             b_desc_q;
  logic                    b_fire;
  logic                    out_free;
  logic                    rd_en;
  logic [TBL_W-1:0]        rd_data;

  logic [COUNTER_BITS-1:0] new_bytes, new_pkts;
  logic                    we;
  logic [TBL_AW-1:0]       waddr;
  logic [TBL_W-1:0]        wdata;

  logic                    m_valid_q;
  logic [M_DATA_W-1:0]     m_data_q;
  logic [M_USER_W-1:0]     m_user_q;

  // Handshake between queue, update stage and output register
  assign out_free   = !m_valid_q || m_ready_i;
  assign b_fire     = b_valid_q && out_free;
  assign q_pop_o    = q_valid_i && !clr_q
                   && (!b_valid_q || (b_fire && !b_desc_q.counted));
  assign rd_en      = q_pop_o && q_desc_i.counted;
  assign clr_busy_o = clr_q;

  // Counter table: {packets, bytes} per entry
  iptc_ram #(
    .WIDTH (TBL_W),
    .DEPTH (TBL_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (tbl_index(q_desc_i)),
    .rdata_o (rd_data)
  );

  // Increment and write-back, or zero fill during the clearing pass
  always_comb begin
    new_bytes = rd_data[COUNTER_BITS-1:0] + COUNTER_BITS'(b_desc_q.ip_bytes);
    new_pkts  = rd_data[TBL_W-1:COUNTER_BITS] + 1'b1;
    if (clr_q) begin
      we    = 1'b1;
      waddr = clr_addr_q;
      wdata = '0;
    end else begin
      we    = b_fire && b_desc_q.counted;
      waddr = tbl_index(b_desc_q);
      wdata = {new_pkts, new_bytes};
    end
  end

  // Clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == '1) clr_q <= 1'b0;
    end
  end

  // Update stage holding one summary while its table read completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (q_pop_o) begin
      b_valid_q <= 1'b1;
    end else if (b_fire) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) b_desc_q <= q_desc_i;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (b_fire) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_fire) begin
      m_user_q <= {b_desc_q.dir, b_desc_q.udp, b_desc_q.counted};
      if (b_desc_q.counted) begin
        m_data_q <= {TOTAL_W'(new_pkts), TOTAL_W'(new_bytes), b_desc_q.port};
      end else begin
        m_data_q <= '0;
      end
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;
  assign m_user_o  = m_user_q;

  // Checks
  a_clr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !b_valid_q && !q_pop_o)
    else $error("summary taken during table clearing");

  a_counted_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |=> b_valid_q && b_desc_q.counted)
    else $error("table read without a counted summary in the update stage");

  a_single_rmw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && b_desc_q.counted) |-> !rd_en)
    else $error("second table read while an update is pending");

  a_write_on_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_fire && b_desc_q.counted) |-> we && !clr_q)
    else $error("counted summary left without write-back");

endmodule

`default_nettype wire

FILE: src/ipv4_port_traffic_counter.sv
// Top level of the IPv4 TCP/UDP per-port packet and byte counter.
//
// Input stream: one Ethernet frame byte per transaction on s_axis, tlast on
// the final byte, tuser carries the direction (0 receive, keyed on the
// destination port; 1 transmit, keyed on the source port) sampled at tlast.
// Output stream: one transaction per frame on m_axis. tuser flags whether the
// frame was counted, whether it was UDP and its direction; tdata carries the
// key port and the updated byte and packet totals of that key (all zero when
// the frame was not counted).
// Throughput: one byte per cycle while s_axis_tready is high. A frame summary
// leaves the parser on its last byte; the update side passes uncounted frames
// at one per cycle while m_axis is ready, and takes no new summary while a
// counted frame waits on the table read-modify-write through a single
// registered-read RAM. Path: summary queue, update stage, output register.
// Reset: the counter table is cleared by a sweep over all 262144 entries, one
// entry per cycle; s_axis_tready stays low until it ends.
// Stall: a four-entry summary queue and the output register absorb
// backpressure on m_axis; once the queue fills, s_axis_tready drops.
`default_nettype none

module ipv4_port_traffic_counter (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [iptc_pkg::S_DATA_W-1:0]   s_axis_tdata,  // [7:0] frame_byte
  input  wire logic                            s_axis_tlast,  // last_byte
  input  wire logic                            s_axis_tuser,  // [0] direction
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [15:0] key_port, [79:16] total_bytes, [143:80] total_packets
  output logic [iptc_pkg::M_DATA_W-1:0]        m_axis_tdata,
  // [0] counted, [1] is_udp, [2] traffic_direction
  output logic [iptc_pkg::M_USER_W-1:0]        m_axis_tuser
);

  import iptc_pkg::*;

  logic        accept;
  logic        push;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  logic        clr_busy;
  frame_desc_t push_desc;
  frame_desc_t q_desc;

  assign s_axis_tready = !q_full && !clr_busy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Front: byte parser
  iptc_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .last_i   (s_axis_tlast),
    .dir_i    (s_axis_tuser),
    .push_o   (push),
    .desc_o   (push_desc)
  );

  // Summary queue
  iptc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (push_desc),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .desc_o  (q_desc)
  );

  // Back: counter table update
  iptc_update u_update (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_desc_i   (q_desc),
    .q_pop_o    (q_pop),
    .clr_busy_o (clr_busy),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_o   (m_axis_tdata),
    .m_user_o   (m_axis_tuser)
  );

endmodule

`default_nettype wire
